FILE: design/p2rgb_pkg.sv
`default_nettype none

package p2rgb_pkg;

  // input item kinds, carried in tuser
  localparam logic [1:0] ACT_GAMMA   = 2'd0;
  localparam logic [1:0] ACT_PALETTE = 2'd1;
  localparam logic [1:0] ACT_CONVERT = 2'd2;

  // register indexes, byte address 4*i
  localparam logic [2:0] REG_OUTPUT_FORMAT  = 3'd0;
  localparam logic [2:0] REG_GAMMA_ENABLE   = 3'd1;
  localparam logic [2:0] REG_RED_POSITION   = 3'd2;
  localparam logic [2:0] REG_GREEN_POSITION = 3'd3;
  localparam logic [2:0] REG_BLUE_POSITION  = 3'd4;

  // output formats
  localparam logic FMT_SHIFTED = 1'b0;
  localparam logic FMT_RGB565  = 1'b1;

  localparam logic [4:0] POSITION_MAX = 5'd24;
  localparam int unsigned RAMP_DEPTH = 256;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned RGB_W = 3 * LEVEL_W;
  localparam int unsigned WORD_W = 32;

  // RGB565 field placement
  localparam int unsigned R565_LSB = 11;
  localparam int unsigned G565_LSB = 5;
  localparam int unsigned R565_DROP = 3;
  localparam int unsigned G565_DROP = 2;

  typedef struct packed {
    logic       output_format;
    logic       gamma_enable;
    logic [4:0] red_position;
    logic [4:0] green_position;
    logic [4:0] blue_position;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/p2rgb_ram.sv
`default_nettype none

module p2rgb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/p2rgb_cfg.sv
`default_nettype none

module p2rgb_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output p2rgb_pkg::cfg_t  cfg
);

  import p2rgb_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;
  logic [4:0] pos_clamped;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite && pready;

  // positions above the top saturate
  assign pos_clamped = (pwdata[4:0] > POSITION_MAX) ? POSITION_MAX : pwdata[4:0];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_format  <= FMT_SHIFTED;
      cfg.gamma_enable   <= 1'b0;
      cfg.red_position   <= 5'd16;
      cfg.green_position <= 5'd8;
      cfg.blue_position  <= 5'd0;
    end else if (wr_en) begin
      case (reg_index)
        REG_OUTPUT_FORMAT:  cfg.output_format  <= pwdata[0];
        REG_GAMMA_ENABLE:   cfg.gamma_enable   <= pwdata[0];
        REG_RED_POSITION:   cfg.red_position   <= pos_clamped;
        REG_GREEN_POSITION: cfg.green_position <= pos_clamped;
        REG_BLUE_POSITION:  cfg.blue_position  <= pos_clamped;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    case (reg_index)
      REG_OUTPUT_FORMAT:  prdata[0]   = cfg.output_format;
      REG_GAMMA_ENABLE:   prdata[0]   = cfg.gamma_enable;
      REG_RED_POSITION:   prdata[4:0] = cfg.red_position;
      REG_GREEN_POSITION: prdata[4:0] = cfg.green_position;
      REG_BLUE_POSITION:  prdata[4:0] = cfg.blue_position;
      default:            prdata      = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/p2rgb_pack.sv
`default_nettype none

module p2rgb_pack (
  input  wire logic [23:0]     rgb,
  input  wire p2rgb_pkg::cfg_t cfg,
  output logic      [31:0]     word
);

  import p2rgb_pkg::*;

  logic [LEVEL_W-1:0] red;
  logic [LEVEL_W-1:0] green;
  logic [LEVEL_W-1:0] blue;
  logic [WORD_W-1:0]  shifted;
  logic [WORD_W-1:0]  rgb565;

  assign red   = rgb[23:16];
  assign green = rgb[15:8];
  assign blue  = rgb[7:0];

  // bytes at their positions, overlaps ORed
  assign shifted = (WORD_W'(red) << cfg.red_position)
                 | (WORD_W'(green) << cfg.green_position)
                 | (WORD_W'(blue) << cfg.blue_position);

  // top 5/6/5 bits in the low half
  assign rgb565 = (WORD_W'(red >> R565_DROP) << R565_LSB)
                | (WORD_W'(green >> G565_DROP) << G565_LSB)
                | WORD_W'(blue >> R565_DROP);

  assign word = (cfg.output_format == FMT_RGB565) ? rgb565 : shifted;

endmodule

`default_nettype wire

FILE: design/palette_index_to_rgb.sv
`default_nettype none

// Color lookup table: 8-bit pixel indices in, packed RGB words out, one item
// per clock unless a convert waits behind a full output register. A gamma
// item writes the ramp; a palette load reads it (three copies, one per
// channel) and a convert reads the palette RAM, both registered reads. The
// second stage writes the palette entry or packs the color. A convert that
// follows a palette load of the same slot gets the new color by forwarding.
// Neither table is cleared after reset, so the block takes requests from the
// first cycle; entries must be loaded before they are read. Registers sit at
// APB byte addresses 0x00 output_format, 0x04 gamma_enable, 0x08/0x0c/0x10
// red/green/blue position; gamma is applied as palette entries are stored.
module palette_index_to_rgb #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // entry_index[7:0], red_level[15:8], green_level[23:16], blue_level[31:24],
  // ramp_value[39:32]
  input  wire logic [39:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  // master side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pixel_word[31:0]
  output logic      [31:0] m_axis_tdata,
  output logic             m_axis_tlast,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import p2rgb_pkg::*;

  localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned RAMP_AW = $clog2(RAMP_DEPTH);

  cfg_t cfg;

  logic                in_acc;
  logic [1:0]          in_action;
  logic [7:0]          in_index;
  logic [7:0]          in_red;
  logic [7:0]          in_green;
  logic [7:0]          in_blue;
  logic [7:0]          in_ramp;
  logic                in_range;

  logic                s1_valid;
  logic [1:0]          s1_action;
  logic [7:0]          s1_index;
  logic                s1_in_range;
  logic                s1_last;
  logic [7:0]          s1_red;
  logic [7:0]          s1_green;
  logic [7:0]          s1_blue;
  logic                s1_adv;
  logic                s1_is_conv;

  logic [7:0]          g_red;
  logic [7:0]          g_green;
  logic [7:0]          g_blue;
  logic [RGB_W-1:0]    pal_rdata;
  logic                gamma_we;
  logic                gamma_re;
  logic                pal_re;
  logic                pal_we;
  logic [PAL_AW-1:0]   pal_waddr;
  logic [RGB_W-1:0]    pal_wdata;

  logic                wr_valid;
  logic [PAL_AW-1:0]   wr_addr;
  logic [RGB_W-1:0]    wr_data;
  logic                fwd_hit;
  logic [RGB_W-1:0]    conv_rgb;
  logic [WORD_W-1:0]   conv_word;
  logic                out_load;

  // field unpacking
  assign in_action = s_axis_tuser;
  assign in_index  = s_axis_tdata[7:0];
  assign in_red    = s_axis_tdata[15:8];
  assign in_green  = s_axis_tdata[23:16];
  assign in_blue   = s_axis_tdata[31:24];
  assign in_ramp   = s_axis_tdata[39:32];
  assign in_range  = {1'b0, in_index} < 9'(PALETTE_ENTRIES);

  // flow control: only a convert can stall, behind a full output register
  assign s1_is_conv    = s1_action == ACT_CONVERT;
  assign s1_adv        = s1_valid && (!s1_is_conv || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  p2rgb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // gamma ramp, one copy per channel so all three read in the same cycle
  assign gamma_we = in_acc && in_action == ACT_GAMMA;
  assign gamma_re = in_acc && in_action == ACT_PALETTE;

  p2rgb_ram #(.WIDTH(LEVEL_W), .DEPTH(RAMP_DEPTH)) u_ramp_red (
    .clk (clk), .we (gamma_we), .waddr (RAMP_AW'(in_index)), .wdata (in_ramp),
    .re (gamma_re), .raddr (RAMP_AW'(in_red)), .rdata (g_red)
  );

  p2rgb_ram #(.WIDTH(LEVEL_W), .DEPTH(RAMP_DEPTH)) u_ramp_green (
    .clk (clk), .we (gamma_we), .waddr (RAMP_AW'(in_index)), .wdata (in_ramp),
    .re (gamma_re), .raddr (RAMP_AW'(in_green)), .rdata (g_green)
  );

  p2rgb_ram #(.WIDTH(LEVEL_W), .DEPTH(RAMP_DEPTH)) u_ramp_blue (
    .clk (clk), .we (gamma_we), .waddr (RAMP_AW'(in_index)), .wdata (in_ramp),
    .re (gamma_re), .raddr (RAMP_AW'(in_blue)), .rdata (g_blue)
  );

  // palette, read on convert, written on load in the cycle after it is taken
  assign pal_re    = in_acc && in_action == ACT_CONVERT && in_range;
  assign pal_we    = s1_adv && s1_action == ACT_PALETTE && s1_in_range;
  assign pal_waddr = s1_index[PAL_AW-1:0];
  assign pal_wdata = cfg.gamma_enable ? {g_red, g_green, g_blue}
                                      : {s1_red, s1_green, s1_blue};

  p2rgb_ram #(.WIDTH(RGB_W), .DEPTH(PALETTE_ENTRIES)) u_palette (
    .clk (clk), .we (pal_we), .waddr (pal_waddr), .wdata (pal_wdata),
    .re (pal_re), .raddr (in_index[PAL_AW-1:0]), .rdata (pal_rdata)
  );

  // second stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= in_acc;
    end
  end

  // second stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action   <= in_action;
      s1_index    <= in_index;
      s1_in_range <= in_range;
      s1_last     <= s_axis_tlast;
      s1_red      <= in_red;
      s1_green    <= in_green;
      s1_blue     <= in_blue;
    end
  end

  // latest palette write, covers a read issued in the same cycle as that write
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (pal_we) begin
      wr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      wr_addr <= pal_waddr;
      wr_data <= pal_wdata;
    end
  end

  assign fwd_hit  = wr_valid && wr_addr == s1_index[PAL_AW-1:0];
  assign conv_rgb = !s1_in_range ? '0 : (fwd_hit ? wr_data : pal_rdata);

  p2rgb_pack u_pack (
    .rgb  (conv_rgb),
    .cfg  (cfg),
    .word (conv_word)
  );

  // output register
  assign out_load = s1_adv && s1_is_conv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= conv_word;
      m_axis_tlast <= s1_last;
    end
  end

  // a result only comes from a convert in the second stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s1_valid && s1_action == ACT_CONVERT))
    else $error("result without a convert request");

  // input stalls only behind a convert waiting on a full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && s1_is_conv && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without cause");

  // a blocked convert keeps its place
  a_conv_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_is_conv && m_axis_tvalid && !m_axis_tready)
      |=> (s1_valid && s1_is_conv && $stable(s1_index)))
    else $error("blocked convert lost");

endmodule

`default_nettype wire
